// ===== rtl/core/tks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k score selector package
// Shared widths, reset values and the link type between ranking cells.
// ----------------------------------------------------------------------------
package tks_pkg;

   localparam int MAX_TOP_DEFAULT     = 8;
   localparam int MAX_CLASSES_DEFAULT = 1024;

   localparam int SCORE_W     = 32;
   localparam int TOP_COUNT_W = 4;

   localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 4'd5;

   // what a ranking cell tells its right-hand neighbour
   typedef struct packed {
      logic valid;
      logic ge;
   } link_type;

endpackage

// ===== rtl/core/tks_rank_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k ranking cell
// One slot of the descending list: keeps its entry, takes the new score or
// takes its left neighbour's entry when a request is ranked in.
// ----------------------------------------------------------------------------
module tks_rank_cell #(
   parameter int IDX_W = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              clear,
   input  logic signed [tks_pkg::SCORE_W-1:0] new_score,
   input  logic [IDX_W-1:0]                  new_index,
   input  tks_pkg::link_type                 prev_link,
   input  logic signed [tks_pkg::SCORE_W-1:0] prev_score,
   input  logic [IDX_W-1:0]                  prev_index,
   output tks_pkg::link_type                 own_link,
   output logic signed [tks_pkg::SCORE_W-1:0] own_score,
   output logic [IDX_W-1:0]                  own_index,
   output logic                              next_valid,
   output logic signed [tks_pkg::SCORE_W-1:0] next_score,
   output logic [IDX_W-1:0]                  next_index
);

   logic                              valid_ff;
   logic signed [tks_pkg::SCORE_W-1:0] score_ff;
   logic [IDX_W-1:0]                  index_ff;
   logic                              ge;

   // equal scores: the earlier entry stays ahead
   assign ge = valid_ff && (score_ff >= new_score);

   always_comb begin
      next_valid = valid_ff | prev_link.valid;
      if (ge) begin
         next_score = score_ff;
         next_index = index_ff;
      end else if (prev_link.ge) begin
         next_score = new_score;
         next_index = new_index;
      end else begin
         next_score = prev_score;
         next_index = prev_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && clear)) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         score_ff <= next_score;
         index_ff <= next_index;
      end
   end

   assign own_link.valid = valid_ff;
   assign own_link.ge    = ge;
   assign own_score      = score_ff;
   assign own_index      = index_ff;

endmodule

// ===== rtl/core/tks_out_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k result cell
// One slot of the result line: loaded in parallel from the ranking cells,
// then shifted towards the head one result per completed handshake.
// ----------------------------------------------------------------------------
module tks_out_cell #(
   parameter int IDX_W = 10
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic                              shift,
   input  logic signed [tks_pkg::SCORE_W-1:0] load_score,
   input  logic [IDX_W-1:0]                  load_index,
   input  logic signed [tks_pkg::SCORE_W-1:0] shift_score,
   input  logic [IDX_W-1:0]                  shift_index,
   output logic signed [tks_pkg::SCORE_W-1:0] score,
   output logic [IDX_W-1:0]                  index
);

   logic signed [tks_pkg::SCORE_W-1:0] score_ff;
   logic [IDX_W-1:0]                  index_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         score_ff <= load_score;
         index_ff <= load_index;
      end else if (shift) begin
         score_ff <= shift_score;
         index_ff <= shift_index;
      end
   end

   assign score = score_ff;
   assign index = index_ff;

endmodule

// ===== rtl/core/top_k_score_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k score selector
// Streams a score vector, one score per request, and reports the best
// top_count classes, best first, after the final score.
//
// Input: req_score with req_last_score on the final score of a vector. One
// request is ranked in every cycle unless stalled; the compare-insert is done
// in parallel by a row of MAX_TOP cells, each comparing its entry with the
// new score. Output: rsp_class_index, rsp_top_score, rsp_last_result on the
// final result. Results start the cycle after the final score was taken and
// leave at one per cycle when not stalled, from a shift line of MAX_TOP
// registers. Ties keep the earlier class ahead; slots not filled report 0.
// While that line drains, ordinary scores keep flowing; only a final score
// is held off (req_stall) until the line has room. A stalled receiver holds
// the current result and, through that, the next final score.
// csr_write_enable writes top_count (0 acts as 1, above MAX_TOP as MAX_TOP).
// Reset empties the list, the position counter and the result line and sets
// top_count to 5.
// ----------------------------------------------------------------------------
module top_k_score_selector #(
   parameter int MAX_TOP     = tks_pkg::MAX_TOP_DEFAULT,
   parameter int MAX_CLASSES = tks_pkg::MAX_CLASSES_DEFAULT,
   parameter int IDX_W       = $clog2(MAX_CLASSES)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [tks_pkg::SCORE_W-1:0]     req_score,
   input  logic                                  req_last_score,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [IDX_W-1:0]                      rsp_class_index,
   output logic signed [tks_pkg::SCORE_W-1:0]     rsp_top_score,
   output logic                                  rsp_last_result,
   input  logic                                  csr_write_enable,
   input  logic [tks_pkg::TOP_COUNT_W-1:0]       csr_write_data
);

   localparam int CNT_W = $clog2(MAX_TOP + 1);
   localparam int CMP_W = 8;

   logic [tks_pkg::TOP_COUNT_W-1:0] top_count_ff;
   logic [IDX_W-1:0]                position_ff;
   logic [IDX_W-1:0]                position_in;
   logic [CNT_W-1:0]                remain_ff;
   logic [CNT_W-1:0]                remain_in;
   logic [CNT_W-1:0]                count_eff;
   logic [CMP_W-1:0]                count_wide;

   logic req_accept;
   logic rsp_accept;
   logic out_free;
   logic load;

   tks_pkg::link_type                 chain_link  [MAX_TOP+1];
   logic signed [tks_pkg::SCORE_W-1:0] chain_score [MAX_TOP+1];
   logic [IDX_W-1:0]                  chain_index [MAX_TOP+1];
   logic                              cell_valid  [MAX_TOP];
   logic signed [tks_pkg::SCORE_W-1:0] cell_score  [MAX_TOP];
   logic [IDX_W-1:0]                  cell_index  [MAX_TOP];
   logic signed [tks_pkg::SCORE_W-1:0] out_score   [MAX_TOP+1];
   logic [IDX_W-1:0]                  out_index   [MAX_TOP+1];

   // handshakes
   assign rsp_valid  = (remain_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign out_free   = (remain_ff == '0) || ((remain_ff == CNT_W'(1)) && rsp_accept);
   assign req_stall  = req_last_score && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign load       = req_accept && req_last_score;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= tks_pkg::TOP_COUNT_RESET;
      end else if (csr_write_enable) begin
         top_count_ff <= csr_write_data;
      end
   end

   always_comb begin
      count_wide = CMP_W'(top_count_ff);
      if (count_wide == '0) begin
         count_wide = CMP_W'(1);
      end else if (count_wide > CMP_W'(MAX_TOP)) begin
         count_wide = CMP_W'(MAX_TOP);
      end
      count_eff = count_wide[CNT_W-1:0];
   end

   // class position
   always_comb begin
      if (position_ff == IDX_W'(MAX_CLASSES - 1)) begin
         position_in = '0;
      end else begin
         position_in = position_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load) begin
         position_ff <= '0;
      end else if (req_accept) begin
         position_ff <= position_in;
      end
   end

   // ranking row
   assign chain_link[0].valid = 1'b1;
   assign chain_link[0].ge    = 1'b1;
   assign chain_score[0]      = '0;
   assign chain_index[0]      = '0;

   // result line tail
   assign out_score[MAX_TOP] = '0;
   assign out_index[MAX_TOP] = '0;

   for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
      tks_rank_cell #(
         .IDX_W (IDX_W)
      ) u_rank (
         .clock      (clock),
         .reset      (reset),
         .accept     (req_accept),
         .clear      (req_last_score),
         .new_score  (req_score),
         .new_index  (position_ff),
         .prev_link  (chain_link[i]),
         .prev_score (chain_score[i]),
         .prev_index (chain_index[i]),
         .own_link   (chain_link[i+1]),
         .own_score  (chain_score[i+1]),
         .own_index  (chain_index[i+1]),
         .next_valid (cell_valid[i]),
         .next_score (cell_score[i]),
         .next_index (cell_index[i])
      );

      tks_out_cell #(
         .IDX_W (IDX_W)
      ) u_out (
         .clock       (clock),
         .load        (load),
         .shift       (rsp_accept),
         .load_score  (cell_valid[i] ? cell_score[i] : '0),
         .load_index  (cell_valid[i] ? cell_index[i] : '0),
         .shift_score (out_score[i+1]),
         .shift_index (out_index[i+1]),
         .score       (out_score[i]),
         .index       (out_index[i])
      );
   end

   // results left to send
   always_comb begin
      remain_in = remain_ff;
      if (load) begin
         remain_in = count_eff;
      end else if (rsp_accept) begin
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   assign rsp_class_index = out_index[0];
   assign rsp_top_score   = out_score[0];
   assign rsp_last_result = (remain_ff == CNT_W'(1));

   // checks
   a_results_follow_last : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("no result after final score");

   a_list_cleared : assert property (@(posedge clock) disable iff (reset)
      load |=> !chain_link[1].valid && !chain_link[MAX_TOP].valid)
      else $error("ranking row not cleared after final score");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_last_score && (remain_ff > CNT_W'(1))) |-> req_stall)
      else $error("final score taken while results still pending");

   a_drain_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_result && !load) |=> !rsp_valid)
      else $error("result line not empty after final result");

endmodule

// ===== sim/tb_top_k_score_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k score selector testbench
// Streams score vectors into the selector and checks each reported class
// against a ranking model kept in step with every accepted request, or
// a typed table entry. Directed vectors from a short table come first, then
// random vectors under several top_count settings and handshake idling mixes.
// ----------------------------------------------------------------------------
module tb_top_k_score_selector;

   localparam int MAX_TOP        = tks_pkg::MAX_TOP_DEFAULT;
   localparam int IDX_W          = $clog2(tks_pkg::MAX_CLASSES_DEFAULT);
   localparam int SCORE_W        = tks_pkg::SCORE_W;
   localparam int TOP_COUNT_W    = tks_pkg::TOP_COUNT_W;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 16;
   localparam int HOLD_CYCLES    = 60;
   localparam int MAX_GAP        = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 30;
   localparam int PHASES         = 8;
   localparam int PRESSURE_PHASE = 4;
   localparam int DIRECTED_ROWS  = 20;

   localparam int PHASE_COUNT [PHASES] = '{5, 1, 8, 0, 15, 9, 3, 12};
   localparam int PHASE_IDLE  [PHASES] = '{0, 79, 0, 17, 0, 17, 79, 0};
   localparam int PHASE_STALL [PHASES] = '{0, 0, 79, 17, 0, 17, 0, 79};

   typedef struct {
      logic [IDX_W-1:0]          class_index;
      logic signed [SCORE_W-1:0] top_score;
      logic                      last_result;
   } class_result_type;

   // wr_cfg, cfg, score, last, typed, t_index, t_score
   typedef struct packed {
      bit                   wr_cfg;
      bit [TOP_COUNT_W-1:0] cfg;
      bit [SCORE_W-1:0]     score;
      bit                   last;
      bit                   typed;
      bit [IDX_W-1:0]       t_index;
      bit [SCORE_W-1:0]     t_score;
   } directed_row_type;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b1, 4'd1,  32'h7FFF_FFFF, 1'b1, 1'b1, 10'd0, 32'h7FFF_FFFF},
      '{1'b0, 4'd0,  32'h8000_0000, 1'b1, 1'b1, 10'd0, 32'h8000_0000},
      // equal scores, earlier class first
      '{1'b0, 4'd0,  32'h0000_0005, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h0000_0005, 1'b1, 1'b1, 10'd0, 32'h0000_0005},
      // count of zero acts as one
      '{1'b1, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h8000_0000, 1'b1, 1'b1, 10'd1, 32'h7FFF_FFFF},
      // count above eight acts as eight, unfilled slots report zero
      '{1'b1, 4'd15, 32'h0000_0003, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h0000_0003, 1'b1, 1'b0, 10'd0, 32'h0000_0000},
      // ten scores into eight slots
      '{1'b1, 4'd8,  32'h0100_0000, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'hFF00_0000, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h8000_0000, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h0000_0001, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h0100_0000, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h00FF_FFFF, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h8000_0001, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'h7FFF_FFFE, 1'b0, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b0, 4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 10'd0, 32'h0000_0000},
      '{1'b1, 4'd4,  32'h0000_0000, 1'b1, 1'b0, 10'd0, 32'h0000_0000}
   };

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic signed [SCORE_W-1:0] req_score        = '0;
   logic                      req_last_score   = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic [IDX_W-1:0]          rsp_class_index;
   logic signed [SCORE_W-1:0] rsp_top_score;
   logic                      rsp_last_result;
   logic                      csr_write_enable = 1'b0;
   logic [TOP_COUNT_W-1:0]    csr_write_data   = '0;

   // ranking model state
   logic signed [SCORE_W-1:0] best_score [MAX_TOP];
   logic [IDX_W-1:0]          best_index [MAX_TOP];
   int                        filled_slots;
   logic [IDX_W-1:0]          next_position;
   logic [TOP_COUNT_W-1:0]    top_count;
   class_result_type          ranked_out [$];
   class_result_type          expected_results [$];

   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   int          holds_asked = 0;
   int          holds_done  = 0;
   int          hold_left   = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   top_k_score_selector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_score        (req_score),
      .req_last_score   (req_last_score),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_class_index  (rsp_class_index),
      .rsp_top_score    (rsp_top_score),
      .rsp_last_result  (rsp_last_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   function automatic void clear_ranking();
      int i;
      for (i = 0; i < MAX_TOP; i++) begin
         best_score[i] = {1'b1, {(SCORE_W-1){1'b0}}};
         best_index[i] = '0;
      end
      filled_slots  = 0;
      next_position = '0;
   endfunction

   // ranks one score in; on the final score leaves the report in ranked_out
   function automatic void rank_score(input logic signed [SCORE_W-1:0] s, input logic last);
      int               slot;
      int               j;
      int               n;
      int               k;
      int               i;
      class_result_type r;
      ranked_out.delete();
      n    = filled_slots;
      slot = 0;
      while (slot < n && best_score[slot] >= s) slot++;
      if (slot < MAX_TOP) begin
         j = (n < MAX_TOP) ? n : MAX_TOP - 1;
         while (j > slot) begin
            best_score[j] = best_score[j-1];
            best_index[j] = best_index[j-1];
            j--;
         end
         best_score[slot] = s;
         best_index[slot] = next_position;
      end
      if (n < MAX_TOP) n++;
      filled_slots  = n;
      next_position = next_position + 1'b1;
      if (last) begin
         k = (top_count == 0) ? 1 : (top_count > MAX_TOP) ? MAX_TOP : int'(top_count);
         for (i = 0; i < k; i++) begin
            r.class_index = (i < filled_slots) ? best_index[i] : '0;
            r.top_score   = (i < filled_slots) ? best_score[i] : '0;
            r.last_result = (i == k - 1);
            ranked_out.insert(ranked_out.size(), r);
         end
         clear_ranking();
      end
   endfunction

   function automatic logic signed [SCORE_W-1:0] random_score();
      logic signed [SCORE_W-1:0] s;
      case ($urandom_range(9))
         0: s = {1'b0, {(SCORE_W-1){1'b1}}};
         1: s = {1'b1, {(SCORE_W-1){1'b0}}};
         2, 3, 4: s = SCORE_W'($urandom_range(8)) - SCORE_W'(4);
         default: s = $urandom;
      endcase
      return s;
   endfunction

   task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic last,
                             input bit typed, input logic [IDX_W-1:0] t_index,
                             input logic signed [SCORE_W-1:0] t_score);
      int               gap;
      int               i;
      class_result_type typed_result;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_score      <= s;
      req_last_score <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rank_score(s, last);
      if (typed) begin
         typed_result.class_index = t_index;
         typed_result.top_score   = t_score;
         typed_result.last_result = 1'b1;
         expected_results.insert(expected_results.size(), typed_result);
      end else begin
         for (i = 0; i < ranked_out.size(); i++)
            expected_results.insert(expected_results.size(), ranked_out[i]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_top_count(input logic [TOP_COUNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      top_count = value;
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin : response_check
      class_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: class_index %0d top_score %0d last_result %0b",
                     $time, rsp_class_index, rsp_top_score, rsp_last_result);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_class_index !== want.class_index) begin
               $display("%0t: class_index expected %0d, actual %0d",
                        $time, want.class_index, rsp_class_index);
               error_count++;
            end
            if (rsp_top_score !== want.top_score) begin
               $display("%0t: top_score expected %0d, actual %0d",
                        $time, want.top_score, rsp_top_score);
               error_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $display("%0t: last_result expected %0b, actual %0b",
                        $time, want.last_result, rsp_last_result);
               error_count++;
            end
         end
      end
      if (holds_done != holds_asked) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      int sent;
      int len;
      int i;
      clear_ranking();
      top_count = tks_pkg::TOP_COUNT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].wr_cfg) begin
            wait_drained();
            write_top_count(directed_rows[r].cfg);
         end
         send_score(directed_rows[r].score, directed_rows[r].last, directed_rows[r].typed,
                    directed_rows[r].t_index, directed_rows[r].t_score);
      end

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         write_top_count(TOP_COUNT_W'(PHASE_COUNT[p]));
         idle_pct  = PHASE_IDLE[p];
         stall_pct = PHASE_STALL[p];
         // receiver holds off while vectors keep coming, so final scores back up
         if (p == PRESSURE_PHASE) holds_asked++;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            case ($urandom_range(9))
               0: len = 1;
               7, 8: len = $urandom_range(24, 10);
               9: len = $urandom_range(40, 25);
               default: len = $urandom_range(9, 2);
            endcase
            for (i = 0; i < len; i++) send_score(random_score(), i == len - 1, 1'b0, '0, '0);
            sent += len;
         end
      end

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== top_k_score_selector.f =====
rtl/core/tks_pkg.sv
rtl/core/tks_rank_cell.sv
rtl/core/tks_out_cell.sv
rtl/core/top_k_score_selector.sv
sim/tb_top_k_score_selector.sv
